FILE: rtl/core/hawin_pkg.sv
`timescale 1ns / 1ps

package hawin_pkg;

   localparam int MAX_ELEMENTS = 4096;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int NU_W         = IDX_W + 1;
   localparam int BLK_W        = 12;
   localparam int E_W          = 13;
   localparam int TAG_W        = 8;
   localparam int HIDX_W       = 24;
   localparam int HANDLE_W     = TAG_W + HIDX_W;
   localparam int FIRST_W      = BLK_W + E_W;
   localparam int DIV_CNT_W    = $clog2(IDX_W);

   localparam logic [E_W-1:0]  ELEMS_MAX   = E_W'(MAX_ELEMENTS);
   localparam logic [NU_W-1:0] NU_LIMIT    = NU_W'(MAX_ELEMENTS);

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_ACCESS = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX  = 3'd1;
   localparam logic [2:0] ST_WRONG_TAG  = 3'd2;
   localparam logic [2:0] ST_NOT_IN_USE = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   localparam logic CSR_OWNER_TAG = 1'b0;
   localparam logic CSR_ELEMS     = 1'b1;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [HANDLE_W-1:0] handle;
      logic                mark_dirty;
   } req_item_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] handle_out;
      logic                reused;
      logic                window_hit;
      logic                writeback_valid;
      logic [BLK_W-1:0]    writeback_block;
      logic                load_valid;
      logic [BLK_W-1:0]    load_block;
      logic [BLK_W-1:0]    slot_offset;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: rtl/core/hawin_ram.sv
`timescale 1ns / 1ps

module hawin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/hawin_div.sv
`timescale 1ns / 1ps

module hawin_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [hawin_pkg::IDX_W-1:0] dividend,
   input  logic [hawin_pkg::E_W-1:0]   divisor,
   output logic [hawin_pkg::IDX_W-1:0] quotient,
   output logic [hawin_pkg::IDX_W-1:0] remainder,
   output hawin_pkg::div_stat_type    stat
);

   import hawin_pkg::*;

   logic [IDX_W-1:0]     quo_ff, quo_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [IDX_W:0]       shifted;
   logic                 fits;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[IDX_W-1]};
   assign fits    = shifted >= divisor;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? IDX_W'(shifted - divisor) : shifted[IDX_W-1:0];
         quo_in = {quo_ff[IDX_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/core/handle_allocator_with_window_top.sv
`timescale 1ns / 1ps

// handle allocator with a one-block resident window
// request channel: req_valid / req_stall / req_data (alloc, free or access)
// response channel: rsp_valid / rsp_stall / rsp_data, one response per request
// csr port: csr_wr_en, csr_index (0 owner tag, 1 elements per block), csr_wdata
// rejected requests (bad handle, wrong tag, full) go from idle straight to
// the output state; valid requests pass the multiply, compare and finish
// states on a window hit, and on a miss wait for the 12-step serial divider
// that finds the new block; one request is worked on at a time; req_stall is
// high until the sequencer is back in idle, and only then is a new one taken
// the response sits in an output register; a new request is taken while it
// waits, and the sequencer holds its finished result until rsp_stall drops
// reset: tag 1, 64 elements per block, empty free list, next index 1,
// window on block 0 and clean; no clearing pass is needed since the in-use
// store is only read below the next unused index
module handle_allocator_with_window_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hawin_pkg::req_item_type       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hawin_pkg::rsp_item_type       rsp_data,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [hawin_pkg::E_W-1:0]     csr_wdata
);

   import hawin_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [TAG_W-1:0]   tag_ff;
   logic [E_W-1:0]     elems_ff;
   logic [NU_W-1:0]    nu_ff, nu_in;
   logic [IDX_W-1:0]   fh_ff, fh_in;
   logic [BLK_W-1:0]   win_blk_ff, win_blk_in;
   logic               dirty_ff, dirty_in;

   logic [1:0]         kind_ff, kind_in;
   logic [IDX_W-1:0]   el_ff, el_in;
   logic               mod_ff, mod_in;
   logic               reused_ff, reused_in;
   logic [FIRST_W-1:0] first_ff, first_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               inuse_ff, inuse_in;
   logic [IDX_W-1:0]   link_ff, link_in;
   rsp_item_type       res_ff, res_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic [E_W-1:0]     eff;
   logic [FIRST_W-1:0] prod;
   logic               ge;
   logic [IDX_W-1:0]   diff;
   logic               accept;
   logic [HIDX_W-1:0]  req_idx;

   logic               div_start;
   logic [IDX_W-1:0]   div_quo, div_rem;
   div_stat_type       div_stat;

   logic               inuse_we, inuse_wd;
   logic [0:0]         inuse_rd;
   logic               link_we;
   logic [IDX_W-1:0]   link_rd;

   assign eff = (elems_ff == '0) ? E_W'(1) : ((elems_ff > ELEMS_MAX) ? ELEMS_MAX : elems_ff);
   assign prod = {{E_W{1'b0}}, win_blk_ff} * {{BLK_W{1'b0}}, eff};
   assign ge   = {{(FIRST_W-IDX_W){1'b0}}, el_ff} >= first_ff;
   assign diff = el_ff - first_ff[IDX_W-1:0];

   assign accept  = req_valid && !req_stall;
   assign req_idx = req_data.handle[HIDX_W-1:0];

   hawin_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (el_ff),
      .divisor   (eff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   hawin_ram #(.WIDTH(1), .DEPTH(MAX_ELEMENTS)) u_inuse_ram (
      .clock   (clock),
      .wr_en   (inuse_we),
      .wr_addr (el_ff),
      .wr_data (inuse_wd),
      .rd_addr (el_ff),
      .rd_data (inuse_rd)
   );

   hawin_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (el_ff),
      .wr_data (fh_ff),
      .rd_addr (fh_ff),
      .rd_data (link_rd)
   );

   always_comb begin
      state_in     = state_ff;
      nu_in        = nu_ff;
      fh_in        = fh_ff;
      win_blk_in   = win_blk_ff;
      dirty_in     = dirty_ff;
      kind_in      = kind_ff;
      el_in        = el_ff;
      mod_in       = mod_ff;
      reused_in    = reused_ff;
      first_in     = first_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      inuse_in     = inuse_ff;
      link_in      = link_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      inuse_we     = 1'b0;
      inuse_wd     = 1'b0;
      link_we      = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in    = '0;
               kind_in   = req_data.req_type;
               reused_in = 1'b0;
               state_in  = S_OUT;
               if (req_data.req_type == REQ_ALLOC) begin
                  mod_in = 1'b1;
                  if (fh_ff != '0 && {1'b0, fh_ff} < nu_ff) begin
                     el_in     = fh_ff;
                     reused_in = 1'b1;
                     state_in  = S_MUL;
                  end else if (fh_ff == '0 && nu_ff < NU_LIMIT) begin
                     el_in    = nu_ff[IDX_W-1:0];
                     state_in = S_MUL;
                  end else begin
                     res_in.status = ST_FULL;
                  end
               end else if (req_data.req_type != REQ_FREE && req_data.req_type != REQ_ACCESS
                            || req_data.handle == '0) begin
                  res_in.status = ST_BAD_INDEX;
               end else if (req_data.handle[HANDLE_W-1:HIDX_W] != tag_ff) begin
                  res_in.status = ST_WRONG_TAG;
               end else if (req_idx == '0 || req_idx >= HIDX_W'(nu_ff)
                            || req_idx >= HIDX_W'(MAX_ELEMENTS)) begin
                  res_in.status = ST_BAD_INDEX;
               end else begin
                  el_in    = req_idx[IDX_W-1:0];
                  mod_in   = (req_data.req_type == REQ_FREE) || req_data.mark_dirty;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            first_in = prod;
            state_in = S_CMP;
         end
         S_CMP: begin
            inuse_in = inuse_rd[0];
            link_in  = link_rd;
            hit_in   = ge && ({1'b0, diff} < eff);
            slot_in  = diff;
            if (ge && ({1'b0, diff} < eff)) begin
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in            = '0;
            res_in.reused     = reused_ff;
            res_in.window_hit = hit_ff;
            if (hit_ff) begin
               res_in.slot_offset = slot_ff;
               dirty_in           = dirty_ff || mod_ff;
            end else begin
               res_in.writeback_valid = dirty_ff;
               res_in.writeback_block = dirty_ff ? win_blk_ff : '0;
               res_in.load_valid      = 1'b1;
               res_in.load_block      = div_quo;
               res_in.slot_offset     = div_rem;
               win_blk_in             = div_quo;
               dirty_in               = mod_ff;
            end
            if (kind_ff == REQ_ALLOC) begin
               res_in.handle_out = {tag_ff, {(HIDX_W-IDX_W){1'b0}}, el_ff};
               inuse_we          = 1'b1;
               inuse_wd          = 1'b1;
               if (reused_ff) begin
                  fh_in = link_ff;
               end else begin
                  nu_in = nu_ff + 1'b1;
               end
            end else if (!inuse_ff) begin
               res_in.status = ST_NOT_IN_USE;
            end else if (kind_ff == REQ_FREE) begin
               inuse_we = 1'b1;
               inuse_wd = 1'b0;
               link_we  = 1'b1;
               fh_in    = el_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tag_ff       <= TAG_W'(1);
         elems_ff     <= E_W'(64);
         nu_ff        <= NU_W'(1);
         fh_ff        <= '0;
         win_blk_ff   <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nu_ff        <= nu_in;
         fh_ff        <= fh_in;
         win_blk_ff   <= win_blk_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == CSR_OWNER_TAG) begin
               tag_ff <= csr_wdata[TAG_W-1:0];
            end else begin
               elems_ff <= csr_wdata;
            end
         end
      end
      kind_ff     <= kind_in;
      el_ff       <= el_in;
      mod_ff      <= mod_in;
      reused_ff   <= reused_in;
      first_ff    <= first_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      inuse_ff    <= inuse_in;
      link_ff     <= link_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/hawin_checker.sv
`timescale 1ns / 1ps

module hawin_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  hawin_pkg::req_item_type req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  hawin_pkg::rsp_item_type rsp_data,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [hawin_pkg::E_W-1:0] csr_wdata,
   output int                      mismatch_count,
   output int                      owed_count
);

   import hawin_pkg::*;

   logic [TAG_W-1:0]  tag_reg;
   logic [E_W-1:0]    elems_reg;
   int unsigned       next_idx;
   int unsigned       free_head;
   logic [HIDX_W-1:0] link_mem [MAX_ELEMENTS];
   logic              in_use_mem [MAX_ELEMENTS];
   int unsigned       win_block;
   logic              win_dirty;

   rsp_item_type      owed_rsp_q [$];

   function automatic rsp_item_type serve_request(req_item_type rq);
      rsp_item_type r;
      int unsigned  idx, slot, e, base, nb;
      logic         touch, mark;
      r = '0;
      touch = 1'b0;
      mark = 1'b1;
      idx = 32'(rq.handle[HIDX_W-1:0]);
      if (rq.req_type == REQ_ALLOC) begin
         if (free_head != 0 && free_head < next_idx) begin
            slot = free_head;
            free_head = 32'(link_mem[slot]);
            r.reused = 1'b1;
            touch = 1'b1;
         end else if (free_head == 0 && next_idx < MAX_ELEMENTS) begin
            slot = next_idx;
            next_idx++;
            touch = 1'b1;
         end else begin
            r.status = ST_FULL;
         end
         if (touch) begin
            in_use_mem[slot] = 1'b1;
            r.handle_out = {tag_reg, HIDX_W'(slot)};
            idx = slot;
         end
      end else if (rq.req_type == REQ_UNUSED || rq.handle == '0) begin
         r.status = ST_BAD_INDEX;
      end else if (rq.handle[HANDLE_W-1 -: TAG_W] != tag_reg) begin
         r.status = ST_WRONG_TAG;
      end else if (idx == 0 || idx >= next_idx) begin
         r.status = ST_BAD_INDEX;
      end else begin
         touch = 1'b1;
         mark = (rq.req_type == REQ_FREE) || rq.mark_dirty;
         if (!in_use_mem[idx]) begin
            r.status = ST_NOT_IN_USE;
         end else if (rq.req_type == REQ_FREE) begin
            in_use_mem[idx] = 1'b0;
            link_mem[idx] = HIDX_W'(free_head);
            free_head = idx;
         end
      end
      if (touch) begin
         if (elems_reg == 0) e = 1;
         else if (elems_reg > ELEMS_MAX) e = MAX_ELEMENTS;
         else e = 32'(elems_reg);
         base = win_block * e;
         if (idx < base || idx - base >= e) begin
            nb = (idx / e) % MAX_ELEMENTS;
            if (win_dirty) begin
               r.writeback_valid = 1'b1;
               r.writeback_block = BLK_W'(win_block);
               win_dirty = 1'b0;
            end
            r.load_valid = 1'b1;
            r.load_block = BLK_W'(nb);
            win_block = nb;
            base = nb * e;
         end else begin
            r.window_hit = 1'b1;
         end
         r.slot_offset = BLK_W'(idx - base);
         if (mark) win_dirty = 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string fname, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         tag_reg = 8'd1;
         elems_reg = 13'd64;
         next_idx = 1;
         free_head = 0;
         for (int i = 0; i < MAX_ELEMENTS; i++) in_use_mem[i] = 1'b0;
         win_block = 0;
         win_dirty = 1'b0;
         owed_rsp_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_OWNER_TAG) tag_reg = csr_wdata[TAG_W-1:0];
            else elems_reg = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: item expected none actual %p", $time, rsp_data);
            end else begin
               want = owed_rsp_q.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("handle_out", want.handle_out, rsp_data.handle_out);
               check_field("reused", want.reused, rsp_data.reused);
               check_field("window_hit", want.window_hit, rsp_data.window_hit);
               check_field("writeback_valid", want.writeback_valid,
                           rsp_data.writeback_valid);
               check_field("writeback_block", want.writeback_block,
                           rsp_data.writeback_block);
               check_field("load_valid", want.load_valid, rsp_data.load_valid);
               check_field("load_block", want.load_block, rsp_data.load_block);
               check_field("slot_offset", want.slot_offset, rsp_data.slot_offset);
            end
         end
         if (req_valid && !req_stall) owed_rsp_q.push_back(serve_request(req_data));
      end
      owed_count = owed_rsp_q.size();
   end

endmodule

FILE: tb/tb_handle_allocator_with_window_top.sv
`timescale 1ns / 1ps

module tb_handle_allocator_with_window_top;

   import hawin_pkg::*;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;
   logic         csr_wr_en;
   logic         csr_index;
   logic [E_W-1:0] csr_wdata;

   int mismatch_count;
   int owed_count;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_req = 1'b0;
   logic [TAG_W-1:0] cur_tag = 8'd1;
   int   alloc_cnt = 0;
   int   cycle_cnt = 0;

   handle_allocator_with_window_top i_dut (.*);

   hawin_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic send(input logic [1:0] kind, input logic [HANDLE_W-1:0] h,
                       input logic md);
      req_item_type it;
      it.req_type = kind;
      it.handle = h;
      it.mark_dirty = md;
      if (kind == REQ_ALLOC) alloc_cnt++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (owed_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [E_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_OWNER_TAG) cur_tag = val[TAG_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random();
      int sel, hi;
      logic [TAG_W-1:0] bad_tag;
      hi = (alloc_cnt + 2 < MAX_ELEMENTS) ? alloc_cnt + 2 : MAX_ELEMENTS - 1;
      sel = $urandom_range(99);
      bad_tag = cur_tag ^ TAG_W'($urandom_range(1, 255));
      if (sel < 34)
         send(REQ_ALLOC, $urandom, 1'($urandom));
      else if (sel < 62)
         send(REQ_ACCESS, {cur_tag, HIDX_W'($urandom_range(1, hi))}, 1'($urandom));
      else if (sel < 80)
         send(REQ_FREE, {cur_tag, HIDX_W'($urandom_range(1, hi))}, 1'($urandom));
      else if (sel < 85)
         send(2'($urandom_range(1, 2)),
              {cur_tag, ($urandom_range(1) ? HIDX_W'(0) : HIDX_W'($urandom_range(hi, hi + 3)))},
              1'($urandom));
      else if (sel < 90)
         send(2'($urandom_range(1, 2)), {bad_tag, HIDX_W'($urandom)}, 1'($urandom));
      else if (sel < 93)
         send(2'($urandom_range(1, 2)), '0, 1'($urandom));
      else if (sel < 97)
         send(2'($urandom), $urandom, 1'($urandom));
      else
         send(REQ_UNUSED, {cur_tag, HIDX_W'($urandom_range(1, hi))}, 1'($urandom));
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [TAG_W-1:0] tag, input logic [E_W-1:0] elems,
                            input int n_items, input logic long_hold);
      drain();
      write_csr(CSR_OWNER_TAG, E_W'(tag));
      write_csr(CSR_ELEMS, elems);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (long_hold) hold_req = 1'b1;
      repeat (n_items) send_random();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_OWNER_TAG;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: rejects, first allocs, free and reuse, not-in-use
      send(REQ_ACCESS, 32'h0000_0000, 1'b1);
      send(REQ_FREE, 32'hffff_ffff, 1'b1);
      send(REQ_UNUSED, 32'h0100_0001, 1'b0);
      send(REQ_ACCESS, 32'h0100_0001, 1'b0);
      send(REQ_ALLOC, 32'hffff_ffff, 1'b0);
      send(REQ_ALLOC, 32'h0000_0000, 1'b1);
      send(REQ_ALLOC, 32'h5555_5555, 1'b0);
      send(REQ_ACCESS, 32'h0100_0000, 1'b1);
      send(REQ_FREE, 32'h01ff_ffff, 1'b0);
      send(REQ_ACCESS, 32'h0100_0002, 1'b1);
      send(REQ_FREE, 32'h0100_0002, 1'b0);
      send(REQ_FREE, 32'h0100_0002, 1'b1);
      send(REQ_ACCESS, 32'h0100_0002, 1'b0);
      send(REQ_ALLOC, 32'h0000_0000, 1'b0);
      send(REQ_ACCESS, 32'h0200_0001, 1'b1);
      send(REQ_UNUSED, 32'h0000_0000, 1'b1);
      // block size zero acts as one: every new index misses
      drain();
      write_csr(CSR_ELEMS, E_W'(0));
      send(REQ_ACCESS, 32'h0100_0003, 1'b0);
      send(REQ_ACCESS, 32'h0100_0001, 1'b0);
      send(REQ_FREE, 32'h0100_0001, 1'b0);
      send(REQ_ALLOC, 32'h0000_0000, 1'b0);
      send(REQ_ALLOC, 32'h0000_0000, 1'b0);
      drain();
      write_csr(CSR_OWNER_TAG, E_W'(0));
      send(REQ_ACCESS, 32'h0000_0004, 1'b1);
      send(REQ_ACCESS, 32'h0100_0004, 1'b1);

      run_phase(0, 0, 8'hff, 13'd8, 340, 1'b1);
      run_phase(88, 0, 8'h00, 13'd3, 340, 1'b0);
      run_phase(0, 88, 8'h37, 13'd4096, 340, 1'b0);
      run_phase(14, 14, TAG_W'($urandom), E_W'($urandom_range(1, 100)), 340, 1'b0);

      run_phase(14, 14, TAG_W'($urandom), 13'd1, 85, 1'b0);
      // block size above the largest acts as the largest
      run_phase(0, 0, 8'hff, 13'h1fff, 85, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
